[rtl/wsfc_pkg.sv]
// shared types, constants, suffix table and character tests of the word shape classifier
package wsfc_pkg;

  localparam int unsigned WIN_DEPTH    = 8;
  localparam int unsigned SUFFIX_TABLE = 47;
  localparam int unsigned SUFFIX_CHARS = 7;
  localparam logic [3:0]  COUNT_MAX    = 4'd15;

  // capitalization codes
  localparam logic [2:0] CAP_NONE     = 3'd0;
  localparam logic [2:0] CAP_SENTENCE = 3'd1;
  localparam logic [2:0] CAP_UPPER_DG = 3'd2;
  localparam logic [2:0] CAP_ALL_UP   = 3'd3;
  localparam logic [2:0] CAP_MIXED    = 3'd4;

  // inflection codes
  localparam logic [1:0] INFL_NONE   = 2'd0;
  localparam logic [1:0] INFL_PLURAL = 2'd1;
  localparam logic [1:0] INFL_ED     = 2'd2;
  localparam logic [1:0] INFL_ING    = 2'd3;

  typedef logic [7:0] char_t;
  typedef logic [WIN_DEPTH-1:0][7:0] window_t;

  // word state as seen after the current character, handed to the evaluator
  typedef struct packed {
    logic       start_upper;
    logic       sentence_start;
    logic       seen_lower;
    logic       seen_digit;
    logic       seen_dash;
    logic       number_broken;
    logic       reduced;
    logic [3:0] len;
  } word_flags_t;

  typedef struct packed {
    logic [2:0] cap_class;
    logic       has_hyphen;
    logic [1:0] inflection_class;
    logic [5:0] suffix_class;
    logic       number_flag;
  } result_t;

  // right-justified text: byte k holds the k-th character from the end, zero past the start
  localparam logic [8*SUFFIX_CHARS-1:0] SUFFIX_TEXT [SUFFIX_TABLE] = '{
    "-backed", "-based", "graphy", "meter", "ente", "ment", "ness", "tion",
    "ael", "ary", "ate", "ble", "ent", "ess", "est", "ial", "ian", "ine",
    "ion", "ism", "ist", "ite", "ity", "ive", "ize", "nce", "ogy", "ous",
    "sis", "uan", "al", "an", "as", "er", "ez", "ia", "ic", "ly", "on",
    "or", "os", "um", "us", "a", "i", "o", "y"
  };

  function automatic logic is_upper(input char_t c);
    return (c >= "A") && (c <= "Z");
  endfunction

  function automatic logic is_lower(input char_t c);
    return (c >= "a") && (c <= "z");
  endfunction

  function automatic logic is_digit(input char_t c);
    return (c >= "0") && (c <= "9");
  endfunction

  function automatic logic is_sign(input char_t c);
    return (c == "+") || (c == "-") || (c == "#");
  endfunction

  function automatic logic is_num_punct(input char_t c);
    return is_digit(c) || (c == ".") || (c == ",");
  endfunction

  function automatic logic is_consonant(input char_t c);
    return is_lower(c) && (c != "a") && (c != "e") && (c != "i") && (c != "o") && (c != "u");
  endfunction

  function automatic logic is_letter_ci(input char_t c, input char_t lower);
    return (c == lower) || (c == (lower - 8'd32));
  endfunction

endpackage

[rtl/wsfc_cell.sv]
// one character cell of the shifting word window
module wsfc_cell (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           shift_i,
  input  logic           clear_i,
  input  wsfc_pkg::char_t char_i,
  output wsfc_pkg::char_t char_o
);
  import wsfc_pkg::*;

  char_t char_q, char_d;

  always_comb begin
    char_d = char_q;
    if (shift_i) begin
      char_d = clear_i ? '0 : char_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      char_q <= '0;
    end else begin
      char_q <= char_d;
    end
  end

  assign char_o = char_q;

endmodule

[rtl/wsfc_eval.sv]
// shape evaluation of a finished word: number test, caps, hyphen, inflection, suffix
module wsfc_eval #(
  parameter int unsigned SUFFIX_COUNT = wsfc_pkg::SUFFIX_TABLE
) (
  input  wsfc_pkg::window_t     win_i,
  input  wsfc_pkg::word_flags_t flags_i,
  output wsfc_pkg::result_t     res_o
);
  import wsfc_pkg::*;

  char_t      c0, c1, c2;
  logic       broken, check_last, is_number, plural;
  logic [1:0] infl;
  logic [5:0] suf;
  logic [3:0] tlen;
  char_t      tail [SUFFIX_CHARS];

  assign c0 = win_i[0];
  assign c1 = win_i[1];
  assign c2 = win_i[2];

  // number test on the last two characters
  always_comb begin
    broken     = flags_i.number_broken;
    check_last = 1'b1;
    if (flags_i.len >= 4'd2) begin
      priority if ((flags_i.len == 4'd2) && is_sign(c1)) begin
        broken = broken;
      end else if (is_letter_ci(c1, "b") && is_letter_ci(c0, "n")) begin
        check_last = 1'b0;
      end else if (is_num_punct(c1)) begin
        broken = broken;
      end else if (is_letter_ci(c1, "e") && (flags_i.len > 4'd2) && is_digit(c2)) begin
        broken = broken;
      end else begin
        broken = 1'b1;
      end
    end
    if (check_last) begin
      if (!((flags_i.len == 4'd1) && is_sign(c0)) &&
          !(is_num_punct(c0) || is_letter_ci(c0, "m") || is_letter_ci(c0, "d"))) begin
        broken = 1'b1;
      end
    end
    is_number = !broken && flags_i.seen_digit;
  end

  assign plural = (flags_i.len > 4'd2) && (c0 == "s") && (c1 != "s") &&
                  ((c1 == "e") || is_consonant(c1));

  always_comb begin
    infl = INFL_NONE;
    if (flags_i.len > 4'd3) begin
      priority if (plural) begin
        infl = INFL_PLURAL;
      end else if ((c1 == "e") && (c0 == "d")) begin
        infl = INFL_ED;
      end else if ((c2 == "i") && (c1 == "n") && (c0 == "g")) begin
        infl = INFL_ING;
      end else begin
        infl = INFL_NONE;
      end
    end
  end

  // suffix compare after dropping a plural s, lowest table index wins
  assign tlen = flags_i.len - {3'b000, plural};

  always_comb begin
    for (int k = 0; k < SUFFIX_CHARS; k++) begin
      tail[k] = plural ? win_i[k+1] : win_i[k];
    end
  end

  always_comb begin
    logic  hit;
    char_t pc;
    suf = '0;
    for (int i = SUFFIX_TABLE - 1; i >= 0; i--) begin
      hit = (i < SUFFIX_COUNT);
      for (int k = 0; k < SUFFIX_CHARS; k++) begin
        pc = SUFFIX_TEXT[i][8*k +: 8];
        if (pc != 8'h00) begin
          if ((k >= int'(tlen)) || (tail[k] != pc)) begin
            hit = 1'b0;
          end
        end
      end
      if (hit) begin
        suf = 6'(i + 1);
      end
    end
  end

  always_comb begin
    res_o = '0;
    if (is_number) begin
      res_o.number_flag = 1'b1;
    end else begin
      if (flags_i.start_upper) begin
        priority if (flags_i.sentence_start) begin
          res_o.cap_class = CAP_SENTENCE;
        end else if (!flags_i.seen_lower) begin
          res_o.cap_class = flags_i.seen_digit ? CAP_UPPER_DG : CAP_ALL_UP;
        end else begin
          res_o.cap_class = CAP_MIXED;
        end
      end else begin
        res_o.cap_class = CAP_NONE;
      end
      if (!flags_i.reduced) begin
        res_o.has_hyphen       = flags_i.seen_dash;
        res_o.inflection_class = infl;
        res_o.suffix_class     = (flags_i.len > 4'd6) ? suf : 6'd0;
      end
    end
  end

endmodule

[rtl/word_shape_feature_classifier.sv]
// top level of the word shape classifier: cell chain, word flags, result register
//
//   channel  direction  handshake                  payload
//   in       input      in_valid_i / in_stall_o    char_code_i, first_word_i, last_char_i
//   out      output     out_valid_o / out_stall_i  cap_class_o .. number_flag_o
//   cfg      input      cfg_we_i                   cfg_wdata_i (reduced mode)
//
// one character per cycle while the input is not stalled; the result of a word is registered at the edge that takes
// its last character and shows on the next cycle
// the eight window cells and the word flags update in the same cycle as the request
// the input stalls only while a finished result waits and the output stalls
// reset clears the window, the count, the flags, the mode and the output valid
module word_shape_feature_classifier #(
  parameter int unsigned SUFFIX_COUNT = wsfc_pkg::SUFFIX_TABLE
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic       cfg_wdata_i,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] char_code_i,
  input  logic       first_word_i,
  input  logic       last_char_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [2:0] cap_class_o,
  output logic       has_hyphen_o,
  output logic [1:0] inflection_class_o,
  output logic [5:0] suffix_class_o,
  output logic       number_flag_o
);
  import wsfc_pkg::*;

  // request handshake
  logic accept, word_end;

  // window: cell k holds the character k places back
  window_t win_next, win_chars;

  // word state
  logic [3:0]  count_q, count_d, len_now;
  logic        start_upper_q, start_upper_d;
  logic        sentence_q, sentence_d;
  logic        seen_lower_q, seen_lower_d;
  logic        seen_digit_q, seen_digit_d;
  logic        seen_dash_q, seen_dash_d;
  logic        num_broken_q, num_broken_d;
  logic        reduced_q;
  logic        first_char, inner_ok;
  word_flags_t flags;
  result_t     res_now, res_q;
  logic        out_valid_q, out_valid_d;

  assign in_stall_o = out_valid_q && out_stall_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign word_end   = accept && last_char_i;

  // cell chain, the new character enters cell zero
  always_comb begin
    win_next[0] = char_code_i;
    for (int k = 1; k < WIN_DEPTH; k++) begin
      win_next[k] = win_chars[k-1];
    end
  end

  for (genvar k = 0; k < WIN_DEPTH; k++) begin : g_cell
    wsfc_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .shift_i(accept),
      .clear_i(last_char_i),
      .char_i (win_next[k]),
      .char_o (win_chars[k])
    );
  end

  // flags as they stand with the current character included
  assign len_now    = (count_q == COUNT_MAX) ? COUNT_MAX : count_q + 4'd1;
  assign first_char = (count_q == 4'd0);

  // the character two back is now known to be neither last nor next to last
  assign inner_ok = ((count_q == 4'd2) && is_sign(win_next[2])) ||
                    is_num_punct(win_next[2]) ||
                    (is_letter_ci(win_next[2], "e") && (count_q != 4'd2) &&
                     is_digit(win_next[3]));

  always_comb begin
    start_upper_d = first_char ? is_upper(char_code_i) : start_upper_q;
    sentence_d    = first_char ? first_word_i : sentence_q;
    seen_lower_d  = seen_lower_q || is_lower(char_code_i);
    seen_digit_d  = seen_digit_q || is_digit(char_code_i);
    seen_dash_d   = seen_dash_q || (char_code_i == "-");
    num_broken_d  = num_broken_q || ((count_q >= 4'd2) && !inner_ok);
    count_d       = len_now;
  end

  always_comb begin
    flags.start_upper    = start_upper_d;
    flags.sentence_start = sentence_d;
    flags.seen_lower     = seen_lower_d;
    flags.seen_digit     = seen_digit_d;
    flags.seen_dash      = seen_dash_d;
    flags.number_broken  = num_broken_d;
    flags.reduced        = reduced_q;
    flags.len            = len_now;
  end

  wsfc_eval #(
    .SUFFIX_COUNT(SUFFIX_COUNT)
  ) u_eval (
    .win_i  (win_next),
    .flags_i(flags),
    .res_o  (res_now)
  );

  // word state registers, cleared at the end of each word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q       <= '0;
      start_upper_q <= 1'b0;
      sentence_q    <= 1'b0;
      seen_lower_q  <= 1'b0;
      seen_digit_q  <= 1'b0;
      seen_dash_q   <= 1'b0;
      num_broken_q  <= 1'b0;
    end else if (accept) begin
      if (last_char_i) begin
        count_q       <= '0;
        start_upper_q <= 1'b0;
        sentence_q    <= 1'b0;
        seen_lower_q  <= 1'b0;
        seen_digit_q  <= 1'b0;
        seen_dash_q   <= 1'b0;
        num_broken_q  <= 1'b0;
      end else begin
        count_q       <= count_d;
        start_upper_q <= start_upper_d;
        sentence_q    <= sentence_d;
        seen_lower_q  <= seen_lower_d;
        seen_digit_q  <= seen_digit_d;
        seen_dash_q   <= seen_dash_d;
        num_broken_q  <= num_broken_d;
      end
    end
  end

  // mode register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      reduced_q <= 1'b0;
    end else if (cfg_we_i) begin
      reduced_q <= cfg_wdata_i;
    end
  end

  // output register: loads when a word ends, drains when not stalled
  always_comb begin
    out_valid_d = out_valid_q;
    if (word_end) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (word_end) begin
      res_q <= res_now;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign cap_class_o        = res_q.cap_class;
  assign has_hyphen_o       = res_q.has_hyphen;
  assign inflection_class_o = res_q.inflection_class;
  assign suffix_class_o     = res_q.suffix_class;
  assign number_flag_o      = res_q.number_flag;

`ifndef SYNTHESIS
  // a number result carries no other feature
  a_number_alone: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && number_flag_o |->
      cap_class_o == CAP_NONE && !has_hyphen_o &&
      inflection_class_o == INFL_NONE && suffix_class_o == 6'd0)
    else $error("number result with other features set");

  // word state starts fresh after the last character
  a_word_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    word_end |=> count_q == 4'd0 && !seen_digit_q && !num_broken_q && !start_upper_q)
    else $error("word state not cleared after word end");

  // reduced mode leaves only caps and number class
  a_reduced: assert property (@(posedge clk_i) disable iff (!rst_ni)
    word_end && reduced_q |=>
      !has_hyphen_o && inflection_class_o == INFL_NONE && suffix_class_o == 6'd0)
    else $error("reduced mode result carries extra features");

  // a finished word always shows a result on the next cycle
  a_result_shown: assert property (@(posedge clk_i) disable iff (!rst_ni)
    word_end |=> out_valid_o)
    else $error("word end without result");
`endif

endmodule
